// File: sv/grs_pkg.sv
`timescale 1ns / 1ps

package grs_pkg;

    localparam int POS_WIDTH = 32;
    localparam int SEQ_WIDTH = 16;
    localparam int OUT_POS_WIDTH = 32;
    localparam int OUT_SEQ_WIDTH = 16;

    localparam logic [7:0] HEADER_MARK = 8'h3E;
    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam logic [7:0] MIN_GAP_RESET = 8'd3;
    localparam logic [7:0] GAP_CHAR_RESET = 8'd78;

    typedef enum logic [0:0] {
        REG_MIN_GAP  = 1'b0,
        REG_GAP_CHAR = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        CMD_BYTE  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [7:0] min_gap;
        logic [7:0] gap_char;
    } cfg_t;

    typedef struct packed {
        logic [OUT_POS_WIDTH-1:0] region_start;
        logic [OUT_POS_WIDTH-1:0] region_end;
        logic [OUT_SEQ_WIDTH-1:0] sequence_index;
    } result_t;

    function automatic logic [OUT_POS_WIDTH-1:0] pos_out(input logic [POS_WIDTH-1:0] p);
        logic [63:0] wide;
        wide = 64'(p);
        return wide[OUT_POS_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_SEQ_WIDTH-1:0] seq_out(input logic [SEQ_WIDTH-1:0] s);
        logic [63:0] wide;
        wide = 64'(s);
        return wide[OUT_SEQ_WIDTH-1:0];
    endfunction

endpackage

// File: sv/grs_cfg.sv
`timescale 1ns / 1ps

module grs_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  grs_pkg::cfg_reg_t cfg_index,
    input  logic [7:0]        cfg_data,
    output grs_pkg::cfg_t     cfg
);
    import grs_pkg::*;

    logic [7:0] min_gap_reg;
    logic [7:0] gap_char_reg;

    assign cfg_ready = 1'b1;
    assign cfg.min_gap = min_gap_reg;
    assign cfg.gap_char = gap_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= MIN_GAP_RESET;
            gap_char_reg <= GAP_CHAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_GAP:  min_gap_reg <= cfg_data;
                REG_GAP_CHAR: gap_char_reg <= cfg_data;
                default:      min_gap_reg <= min_gap_reg;
            endcase
        end
    end

endmodule

// File: sv/grs_core.sv
`timescale 1ns / 1ps

module grs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cmd,
    input  logic [7:0]        text_byte,
    input  grs_pkg::cfg_t     cfg,
    output logic              res_valid,
    output grs_pkg::result_t  res
);
    import grs_pkg::*;

    logic [POS_WIDTH-1:0] position_reg, position_next;
    logic [POS_WIDTH-1:0] open_start_reg, open_start_next;
    logic [POS_WIDTH-1:0] gap_run_reg, gap_run_next;
    logic [SEQ_WIDTH-1:0] seq_count_reg, seq_count_next;
    logic                 in_header_reg, in_header_next;
    logic                 line_start_reg, line_start_next;

    logic [7:0]           thr;
    logic [POS_WIDTH-1:0] split_end;
    logic [POS_WIDTH-1:0] emit_end;
    logic                 emit;

    assign thr = (cfg.min_gap == 8'd0) ? 8'd1 : cfg.min_gap;
    assign split_end = (gap_run_reg <= position_reg) ? position_reg - gap_run_reg : '0;

    always_comb
    begin
        position_next = position_reg;
        open_start_next = open_start_reg;
        gap_run_next = gap_run_reg;
        seq_count_next = seq_count_reg;
        in_header_next = in_header_reg;
        line_start_next = line_start_reg;
        emit = 1'b0;
        emit_end = position_reg;
        priority if (cmd_t'(cmd) == CMD_FLUSH)
        begin
            emit = (position_reg != '0);
            position_next = '0;
            open_start_next = '0;
            gap_run_next = '0;
            seq_count_next = '0;
            in_header_next = 1'b0;
            line_start_next = 1'b1;
        end
        else if (in_header_reg)
        begin
            if (text_byte == LINE_FEED)
            begin
                in_header_next = 1'b0;
                line_start_next = 1'b1;
            end
        end
        else if (text_byte == LINE_FEED)
        begin
            line_start_next = 1'b1;
        end
        else if (line_start_reg && text_byte == HEADER_MARK)
        begin
            emit = (position_reg != '0);
            if (!(&seq_count_reg))
                seq_count_next = seq_count_reg + 1'b1;
            position_next = '0;
            open_start_next = '0;
            gap_run_next = '0;
            in_header_next = 1'b1;
            line_start_next = 1'b0;
        end
        else
        begin
            line_start_next = 1'b0;
            if (text_byte == cfg.gap_char)
            begin
                if (!(&gap_run_reg))
                    gap_run_next = gap_run_reg + 1'b1;
            end
            else
            begin
                if (gap_run_reg >= POS_WIDTH'(thr))
                begin
                    emit = 1'b1;
                    emit_end = split_end;
                    open_start_next = position_reg;
                end
                gap_run_next = '0;
            end
            if (!(&position_reg))
                position_next = position_reg + 1'b1;
        end
    end

    assign res_valid = accept && emit;
    assign res.region_start = pos_out(open_start_reg);
    assign res.region_end = pos_out(emit_end);
    assign res.sequence_index = seq_out(seq_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            open_start_reg <= '0;
            gap_run_reg <= '0;
            seq_count_reg <= '0;
            in_header_reg <= 1'b0;
            line_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            open_start_reg <= open_start_next;
            gap_run_reg <= gap_run_next;
            seq_count_reg <= seq_count_next;
            in_header_reg <= in_header_next;
            line_start_reg <= line_start_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_header_reg |-> !line_start_reg)
        else $error("header and line start both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_t'(cmd) == CMD_FLUSH) |=> (position_reg == '0 && seq_count_reg == '0))
        else $error("flush did not clear state");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_header_reg |-> (position_reg == '0 && gap_run_reg == '0))
        else $error("position advanced inside header");

endmodule

// File: sv/grs_obuf.sv
`timescale 1ns / 1ps

module grs_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  grs_pkg::result_t push_data,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output grs_pkg::result_t out_data
);
    import grs_pkg::*;

    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room = (count_reg != 2'd2);
    assign out_data = head_reg;
    assign pop = out_valid && out_ready;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = push_data;
                else
                    skid_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    head_next = push_data;
                else
                begin
                    head_next = skid_reg;
                    skid_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("request pushed into full buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && pop) |=> (count_reg == 2'd1 && head_reg == $past(skid_reg)))
        else $error("skid entry not advanced");

endmodule

// File: sv/gap_run_region_splitter.sv
`timescale 1ns / 1ps
// One request per cycle while in_ready is high; results are registered in the
// output buffer. The per-byte state update is one combinational pass.
// A two-entry output buffer keeps in_ready high while one result waits on out_ready.
// Reset (rst_n low, asynchronous): counters cleared, min_gap = 3, gap_char = 'N',
// output buffer empty.
module gap_run_region_splitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  grs_pkg::cfg_reg_t                   cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [7:0]                          text_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [grs_pkg::OUT_POS_WIDTH-1:0]   region_start,
    output logic [grs_pkg::OUT_POS_WIDTH-1:0]   region_end,
    output logic [grs_pkg::OUT_SEQ_WIDTH-1:0]   sequence_index
);
    import grs_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_data;
    logic    res_valid;
    logic    accept;

    assign accept = in_valid && in_ready;

    grs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    grs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .text_byte (text_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    grs_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign region_start = out_data.region_start;
    assign region_end = out_data.region_end;
    assign sequence_index = out_data.sequence_index;

endmodule
